// ===== rtl/core/lrc_pkg.sv =====
// Package with the sizes, codes and shared types of the LRU lookup cache.
package lrc_pkg;

  // Sizes of the cache.
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int KEY_PORT_W = 64;
  localparam int VALUE_W    = 32;
  localparam int STAMP_W    = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Starting bound of the victim search.
  localparam logic [STAMP_W-1:0] STAMP_CEILING = '1;

  // Request codes; the fourth code is unused and leaves the state alone.
  typedef enum logic [1:0] {
    REQ_LOOKUP     = 2'd0,
    REQ_INSERT     = 2'd1,
    REQ_INVALIDATE = 2'd2
  } req_kind_t;

  // Request held for the whole scan and seen by every cell.
  typedef struct packed {
    req_kind_t           kind;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_W-1:0]  value;
  } req_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic                active;
    logic                hit;
    logic [VALUE_W-1:0]  value;
    logic [IDX_W-1:0]    match_idx;
    logic                free;
    logic [IDX_W-1:0]    victim;
    logic [STAMP_W-1:0]  lowest;
  } scan_t;

  // Update broadcast to the cells when a request commits.
  typedef struct packed {
    logic                wr;
    logic                restamp;
    logic                clear;
    logic [IDX_W-1:0]    idx;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_W-1:0]  value;
    logic [STAMP_W-1:0]  stamp;
  } cmd_t;

endpackage

// ===== rtl/core/lrc_cell.sv =====
// One cache entry with its slice of the lookup and victim scan.
module lrc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lrc_pkg::IDX_W-1:0] cell_idx,
  input  lrc_pkg::req_t             req,
  input  lrc_pkg::cmd_t             cmd,
  input  lrc_pkg::scan_t            carry_in,
  output lrc_pkg::scan_t            carry_out,
  output logic                      valid
);
  import lrc_pkg::*;

  logic [KEY_BITS-1:0] key;
  logic [VALUE_W-1:0]  data;
  logic [STAMP_W-1:0]  stamp;
  scan_t               scan_next;

  // Fold this entry into the token passing through.
  always_comb begin
    scan_next = carry_in;
    case (req.kind)
      REQ_LOOKUP: begin
        if (!carry_in.hit && valid && (key == req.key)) begin
          scan_next.hit       = 1'b1;
          scan_next.value     = data;
          scan_next.match_idx = cell_idx;
        end
      end
      REQ_INSERT: begin
        if (!carry_in.free) begin
          if (!valid) begin
            scan_next.free   = 1'b1;
            scan_next.victim = cell_idx;
          end else if (stamp < carry_in.lowest) begin
            scan_next.victim = cell_idx;
            scan_next.lowest = stamp;
          end
        end
      end
      default: begin
        scan_next = carry_in;
      end
    endcase
  end

  // Link register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.active <= 1'b0;
    end else begin
      carry_out <= scan_next;
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.wr && (cmd.idx == cell_idx)) begin
      valid <= 1'b1;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (cmd.wr && (cmd.idx == cell_idx)) begin
      key   <= cmd.key;
      data  <= cmd.value;
      stamp <= cmd.stamp;
    end else if (cmd.restamp && (cmd.idx == cell_idx)) begin
      stamp <= cmd.stamp;
    end
  end

endmodule

// ===== rtl/core/lru_lookup_cache.sv =====
// Top level of the fully associative LRU lookup cache.
//
// Each request (lookup, insert or invalidate) is handled alone: a scan token
// walks the row of ENTRIES cells, one cell per cycle, collecting the first
// matching entry and the replacement victim, and the request then commits
// once the output register can take its result. No new request is taken
// before that commit. Every request gives exactly one result; a finished
// result waits in the output register while the next request is taken.
module lru_lookup_cache (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // lookup_key [63:0], entry_value [95:64]
  input  logic [1:0]   s_tuser,   // req_type [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // found_value [31:0]
  output logic         m_tuser    // hit [0]
);
  import lrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  req_t                req;
  logic                start;
  scan_t               head;
  scan_t               link [ENTRIES];
  scan_t               fin;
  cmd_t                cmd;
  logic [ENTRIES-1:0]  valid_vec;
  logic [ENTRIES-1:0]  link_active;
  logic [STAMP_W-1:0]  use_clock;
  logic [STAMP_W-1:0]  use_clock_next;
  logic                accept;
  logic                commit;
  logic                out_hit;
  logic [VALUE_W-1:0]  out_value;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == ST_COMMIT) && (!m_tvalid || m_tready);

  // Capture the request on its transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.kind  <= req_kind_t'(s_tuser);
      req.key   <= s_tdata[KEY_BITS-1:0];
      req.value <= s_tdata[KEY_PORT_W +: VALUE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= accept;
    end
  end

  // Fresh token entering the first cell.
  always_comb begin
    head.active    = start;
    head.hit       = 1'b0;
    head.value     = '0;
    head.match_idx = '0;
    head.free      = 1'b0;
    head.victim    = '0;
    head.lowest    = STAMP_CEILING;
  end

  // Row of cells.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(i)),
      .req       (req),
      .cmd       (cmd),
      .carry_in  ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
      .carry_out (link[i]),
      .valid     (valid_vec[i])
    );
    assign link_active[i] = link[i].active;
  end

  // Hold the token as it leaves the last cell.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && link[ENTRIES-1].active) begin
      fin <= link[ENTRIES-1];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (link[ENTRIES-1].active) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commit: write, restamp or clear, and advance or reset the use clock.
  always_comb begin
    cmd.wr         = 1'b0;
    cmd.restamp    = 1'b0;
    cmd.clear      = 1'b0;
    cmd.idx        = fin.victim;
    cmd.key        = req.key;
    cmd.value      = req.value;
    cmd.stamp      = use_clock + STAMP_W'(1);
    use_clock_next = use_clock;
    if (commit) begin
      case (req.kind)
        REQ_LOOKUP: begin
          if (fin.hit) begin
            cmd.restamp    = 1'b1;
            cmd.idx        = fin.match_idx;
            use_clock_next = use_clock + STAMP_W'(1);
          end
        end
        REQ_INSERT: begin
          if (req.value != '0) begin
            cmd.wr         = 1'b1;
            use_clock_next = use_clock + STAMP_W'(1);
          end
        end
        REQ_INVALIDATE: begin
          cmd.clear      = 1'b1;
          use_clock_next = '0;
        end
        default: begin
          use_clock_next = use_clock;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock <= '0;
    end else begin
      use_clock <= use_clock_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit   <= (req.kind == REQ_LOOKUP) && fin.hit;
      out_value <= ((req.kind == REQ_LOOKUP) && fin.hit) ? fin.value : '0;
    end
  end

  assign m_tdata = out_value;
  assign m_tuser = out_hit;

  // At most one scan token is in flight.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({start, link_active}))
    else $error("more than one scan token in the cell chain");

  // No request is taken while a token still walks the chain.
  a_idle_chain: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (link_active == '0))
    else $error("request taken while the chain is busy");

  // An invalidate resets the use clock.
  a_clear_clock: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (use_clock == '0))
    else $error("use clock not cleared by invalidate");

  // An insert leaves its entry valid.
  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> valid_vec[$past(cmd.idx)])
    else $error("inserted entry is not valid");

  // Every commit presents a result.
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("commit without a result");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the LRU lookup cache: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_pkg::*;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1950;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [63:0] KEY_ZERO = 64'h0;
  localparam logic [63:0] KEY_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] VAL_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } result_t;

  // One request, with an optional answer typed in by hand.
  typedef struct packed {
    logic [1:0]            kind;
    logic [KEY_PORT_W-1:0] key;
    logic [VALUE_W-1:0]    value;
    logic                  has_exp;
    result_t               exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  lru_lookup_cache dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the cache contents.
  logic [KEY_BITS-1:0] shadow_key   [ENTRIES];
  logic [VALUE_W-1:0]  shadow_data  [ENTRIES];
  logic [STAMP_W-1:0]  shadow_stamp [ENTRIES];
  logic                shadow_valid [ENTRIES];
  logic [STAMP_W-1:0]  use_tick;

  stim_row_t directed_rows[$];
  stim_row_t issued_rows[$];
  result_t   pending_results[$];

  logic [63:0] key_pool [POOL_SIZE];
  int sent_count   = 0;
  int result_count = 0;
  int fail_count   = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;

  task automatic shadow_clear();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
    end
    use_tick = '0;
  endtask

  // Applies one request to the shadow cache and returns the result it gives.
  task automatic cache_model_step(input logic [1:0] kind, input logic [63:0] key_in,
                                  input logic [31:0] value, output result_t res);
    logic [KEY_BITS-1:0] key;
    logic [STAMP_W-1:0]  lowest;
    int                  slot;
    bit                  got_free;
    key = key_in[KEY_BITS-1:0];
    res = '0;
    case (kind)
      REQ_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!res.hit && shadow_valid[i] && shadow_key[i] == key) begin
            use_tick = use_tick + 1'b1;
            shadow_stamp[i] = use_tick;
            res.hit = 1'b1;
            res.value = shadow_data[i];
          end
        end
      end
      REQ_INSERT: begin
        if (value != '0) begin
          // Lowest free slot wins; otherwise the oldest stamp, lowest index on ties.
          slot = 0;
          lowest = STAMP_CEILING;
          got_free = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!got_free) begin
              if (!shadow_valid[i]) begin
                slot = i;
                got_free = 1'b1;
              end else if (shadow_stamp[i] < lowest) begin
                slot = i;
                lowest = shadow_stamp[i];
              end
            end
          end
          shadow_key[slot] = key;
          shadow_data[slot] = value;
          shadow_valid[slot] = 1'b1;
          use_tick = use_tick + 1'b1;
          shadow_stamp[slot] = use_tick;
        end
      end
      REQ_INVALIDATE: shadow_clear();
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [63:0] key,
                         input logic [31:0] value, input logic has_exp,
                         input logic hit, input logic [31:0] found);
    stim_row_t row;
    row.kind = kind;
    row.key = key;
    row.value = value;
    row.has_exp = has_exp;
    row.exp.hit = hit;
    row.exp.value = found;
    directed_rows.push_back(row);
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Sends one request in bursts with random gaps between them.
  task automatic send_req(input stim_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    issued_rows.push_back(row);
    s_tvalid <= 1'b1;
    s_tuser  <= row.kind;
    s_tdata  <= {row.value, row.key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  // Builds one random request, mostly on a small key pool so entries get reused.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int pick;
    row = '0;
    pick = $urandom_range(0, 99);
    row.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : {$urandom, $urandom};
    row.value = $urandom;
    if (pick < 50) begin
      row.kind = REQ_LOOKUP;
    end else if (pick < 94) begin
      row.kind = REQ_INSERT;
      case ($urandom_range(0, 19))
        0: row.value = '0;
        1: row.value = VAL_MAX;
        default: ;
      endcase
    end else if (pick < 96) begin
      row.kind = REQ_INVALIDATE;
    end else begin
      row.kind = REQ_UNUSED;
    end
    return row;
  endfunction

  // Receiver: phases of steady ready, random ready and a full stall.
  int rx_phase_left = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_phase_left <= $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: rx_mode <= 0;
        9:             rx_mode <= 2;
        default:       rx_mode <= 1;
      endcase
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    m_tready <= (rx_mode == 0) ? 1'b1 : (rx_mode == 1) ? 1'($urandom_range(0, 1)) : 1'b0;
  end

  // Watches both sides: predicts on each input transfer, checks each output transfer.
  always @(posedge clk) begin
    stim_row_t row;
    result_t   predicted;
    result_t   want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        row = issued_rows.pop_front();
        cache_model_step(s_tuser, s_tdata[63:0], s_tdata[95:64], predicted);
        pending_results.push_back(row.has_exp ? row.exp : predicted);
      end
      if (m_tvalid && m_tready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result: hit=%0b value=%h", m_tuser, m_tdata));
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.hit || m_tdata !== want.value) begin
            report_failure($sformatf("mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                                     want.hit, want.value, m_tuser, m_tdata));
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  // Main sequence.
  initial begin
    shadow_clear();
    key_pool[0] = KEY_ZERO;
    key_pool[1] = KEY_MAX;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end

    // Directed table: answers typed in where they are obvious.
    add_row(REQ_LOOKUP,     KEY_ZERO, 32'h0,         1'b1, 1'b0, 32'h0);
    add_row(REQ_INSERT,     KEY_MAX,  VAL_MAX,       1'b1, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_MAX,  32'h0,         1'b1, 1'b1, VAL_MAX);
    // An insert of a zero value is dropped.
    add_row(REQ_INSERT,     KEY_ZERO, 32'h0,         1'b1, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_ZERO, 32'h0,         1'b1, 1'b0, 32'h0);
    // The unused code gives an empty result and changes nothing.
    add_row(REQ_UNUSED,     KEY_MAX,  VAL_MAX,       1'b1, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_MAX,  32'h0,         1'b1, 1'b1, VAL_MAX);
    // Duplicate keys coexist and the lower index answers.
    add_row(REQ_INSERT,     KEY_ZERO, 32'h1,         1'b1, 1'b0, 32'h0);
    add_row(REQ_INSERT,     KEY_ZERO, 32'h2,         1'b1, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_ZERO, 32'h0,         1'b1, 1'b1, 32'h1);
    add_row(REQ_INSERT,     64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     64'hA5A5_A5A5_A5A5_A5A5, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     64'h5A5A_5A5A_5A5A_5A5A, VAL_MAX, 1'b0, 1'b0, 32'h0);
    // Invalidate empties the whole cache.
    add_row(REQ_INVALIDATE, KEY_MAX,  VAL_MAX,       1'b1, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_MAX,  32'h0,         1'b1, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_ZERO, 32'h0,         1'b1, 1'b0, 32'h0);
    add_row(REQ_INSERT,     KEY_ZERO, 32'h7,         1'b0, 1'b0, 32'h0);
    add_row(REQ_LOOKUP,     KEY_ZERO, 32'h0,         1'b0, 1'b0, 32'h0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Now and then hold the sender until every result is back.
      if (n == 600 || n == 1400) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (result_count != sent_count) @(posedge clk);
      end
      if ($urandom_range(0, 199) == 0) begin
        key_pool[$urandom_range(2, POOL_SIZE - 1)] = {$urandom, $urandom};
      end
      send_req(random_row());
    end

    // Drain and let the pipeline settle.
    s_tvalid <= 1'b0;
    while (result_count != sent_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
